FILE: rtl/core/lrs_pkg.sv
// ----------------------------------------------------------------------------
// lrs_pkg
// Shared types and elaboration-time sigmoid table builder.
// ----------------------------------------------------------------------------
package lrs_pkg;

   typedef logic signed [31:0] weight_type;
   typedef logic signed [15:0] feature_type;

   localparam int MaxFeatures = 16;
   localparam int SigmoidEntries = 256;

   localparam int ZLimit = 524288;
   localparam longint unsigned Log2eQ16 = 64'd94548;

   function automatic logic [63:0] root2_q16(input int j);
      logic [63:0] r;
      case (j)
         0: r = 64'd92682;
         1: r = 64'd77936;
         2: r = 64'd71468;
         3: r = 64'd68438;
         4: r = 64'd66971;
         5: r = 64'd66250;
         6: r = 64'd65892;
         7: r = 64'd65714;
         8: r = 64'd65625;
         9: r = 64'd65580;
         10: r = 64'd65558;
         11: r = 64'd65547;
         12: r = 64'd65542;
         13: r = 64'd65539;
         default: r = 64'd65537;
      endcase
      return r;
   endfunction

   // restoring division, elaboration only
   function automatic logic [63:0] udiv(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] rem;
      logic [63:0] q;
      rem = '0;
      q = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[63:0], a[i]};
         if (rem >= {1'b0, b}) begin
            rem = rem - {1'b0, b};
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   function automatic logic [15:0] sig_entry(input int i, input int entries);
      logic signed [63:0] zi;
      logic [63:0] t, u, m, e, d, num, p;
      int k;
      zi = -64'sd524288 + $signed(udiv(64'(2 * i + 1) * 64'(ZLimit), 64'(entries)));
      t = (zi < 0) ? 64'(-zi) : 64'(zi);
      u = (t * Log2eQ16) >> 16;
      k = int'(u >> 16);
      m = 64'd65536;
      for (int j = 0; j < 16; j++) begin
         if (u[15 - j])
            m = (m * root2_q16(j) + 64'd32768) >> 16;
      end
      if (k > 20)
         k = 20;
      e = m << k;
      d = e + 64'd65536;
      if (zi >= 0)
         num = e * 64'd65536 + (d >> 1);
      else
         num = 64'h1_0000_0000 + (d >> 1);
      p = udiv(num, d);
      if (p > 64'd65535)
         p = 64'd65535;
      return p[15:0];
   endfunction

endpackage

FILE: rtl/core/logistic_regression_sgd_core.sv
// ----------------------------------------------------------------------------
// logistic_regression_sgd_core
// Online logistic regression with fixed-point SGD on a ring of weight cells.
// ----------------------------------------------------------------------------
// A feature element is taken while idle and can be followed by another in
// the next cycle. The last element of a sample keeps busy high for the result:
// inference runs the states ACC, Z, IDX, TAB, G and ALIGN, where the weight
// ring turns one cell per cycle, then OUT; a training update adds a UPA and
// a UPB step per weight on a shared update multiplier, then BIAS. A read
// goes through READ. Each result shows for one cycle
// on rsp_strobe and must be captured then; there is no backpressure.
module logistic_regression_sgd_core #(
   parameter int MAX_FEATURES    = lrs_pkg::MaxFeatures,
   parameter int SIGMOID_ENTRIES = lrs_pkg::SigmoidEntries
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [1:0]                  req_opcode,
   input  lrs_pkg::feature_type        req_feature_value,
   input  logic                        req_last_feature,
   input  logic                        req_label,
   input  logic [4:0]                  req_weight_index,
   output logic                        rsp_strobe,
   output logic [15:0]                 rsp_probability,
   output logic                        rsp_predicted_class,
   output lrs_pkg::weight_type         rsp_weight_value,
   output logic                        rsp_length_error,
   output logic                        rsp_saturated,
   input  logic                        csr_wr_en,
   input  logic                        csr_index,
   input  logic [15:0]                 csr_data
);
   import lrs_pkg::*;

   localparam int PW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
   localparam int CW = $clog2(MAX_FEATURES + 2);
   localparam int IW = (SIGMOID_ENTRIES > 1) ? $clog2(SIGMOID_ENTRIES) : 1;
   localparam int EW = $clog2(SIGMOID_ENTRIES + 1);

   localparam logic [1:0] OP_INFER = 2'd0;
   localparam logic [1:0] OP_TRAIN = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   localparam logic CSR_RATE = 1'b0;
   localparam logic CSR_NFEAT = 1'b1;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_ACC   = 4'd1;
   localparam logic [3:0] ST_Z     = 4'd2;
   localparam logic [3:0] ST_IDX   = 4'd3;
   localparam logic [3:0] ST_TAB   = 4'd4;
   localparam logic [3:0] ST_G     = 4'd5;
   localparam logic [3:0] ST_ALIGN = 4'd6;
   localparam logic [3:0] ST_UPA   = 4'd7;
   localparam logic [3:0] ST_UPB   = 4'd8;
   localparam logic [3:0] ST_BIAS  = 4'd9;
   localparam logic [3:0] ST_OUT   = 4'd10;
   localparam logic [3:0] ST_READ  = 4'd11;

   function automatic weight_type sat32(input logic signed [32:0] v, output logic s);
      weight_type r;
      s = 1'b0;
      if (v > 33'sh0_7FFF_FFFF) begin
         r = 32'sh7FFF_FFFF;
         s = 1'b1;
      end else if (v < -33'sh0_8000_0000) begin
         r = 32'sh8000_0000;
         s = 1'b1;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // sigmoid table
   logic [15:0] sig_tab [SIGMOID_ENTRIES];
   for (genvar gi = 0; gi < SIGMOID_ENTRIES; gi++) begin : g_tab
      localparam logic [15:0] Val = sig_entry(gi, SIGMOID_ENTRIES);
      assign sig_tab[gi] = Val;
   end

   // weight ring
   weight_type  cw [MAX_FEATURES];
   feature_type cx [MAX_FEATURES];
   weight_type  crd [MAX_FEATURES];
   logic        ring_shift;
   weight_type  tail_w;
   feature_type tail_x;
   logic [PW-1:0] pos_ff, pos_in;

   for (genvar gc = 0; gc < MAX_FEATURES; gc++) begin : g_cell
      weight_type  nw;
      feature_type nx;
      if (gc == MAX_FEATURES - 1) begin : g_tail
         assign nw = tail_w;
         assign nx = tail_x;
      end else begin : g_mid
         assign nw = cw[gc + 1];
         assign nx = cx[gc + 1];
      end
      lrs_cell #(.PW(PW), .IDX(gc)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (ring_shift),
         .w_in     (nw),
         .x_in     (nx),
         .rd_pos   (pos_ff),
         .w_out    (cw[gc]),
         .x_out    (cx[gc]),
         .rd_w     (crd[gc])
      );
   end

   weight_type rd_w_or;
   always_comb begin
      rd_w_or = '0;
      for (int i = 0; i < MAX_FEATURES; i++)
         rd_w_or = rd_w_or | crd[i];
   end

   // registers
   logic [3:0]  state_ff, state_in;
   logic [15:0] rate_ff;
   logic [4:0]  nfeat_ff;
   weight_type  bias_ff, bias_in;
   logic signed [47:0] acc_ff, acc_in;
   logic signed [47:0] prod_ff, prod_in;
   logic        add_ff, add_in;
   logic [CW-1:0] cnt_ff, cnt_in, stored_ff, stored_in, rot_ff, rot_in;
   logic [PW-1:0] upd_ff, upd_in;
   logic        train_ff, train_in, label_ff, label_in, lerr_ff, lerr_in;
   logic        rdbias_ff, rdbias_in, sat_ff, sat_in;
   logic signed [19:0] z_ff, z_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [15:0] p_ff, p_in;
   logic signed [33:0] g_ff, g_in;
   logic signed [49:0] uprod_ff, uprod_in;
   logic        strobe_ff, strobe_in;
   logic [15:0] oprob_ff, oprob_in;
   weight_type  ow_ff, ow_in;
   logic        olerr_ff, olerr_in, osat_ff, osat_in;

   logic [CW-1:0] n_use;
   always_comb begin
      if (nfeat_ff == 5'd0)
         n_use = CW'(1);
      else if (32'(nfeat_ff) > MAX_FEATURES)
         n_use = CW'(MAX_FEATURES);
      else
         n_use = CW'(nfeat_ff);
   end

   logic accept;
   assign accept = start && state_ff == ST_IDLE;
   assign busy = state_ff != ST_IDLE;

   logic signed [48:0] zsum;
   logic [19:0] zoff;
   logic [20+EW-1:0] iprod;
   logic signed [16:0] err;
   logic signed [21:0] wdelta;
   logic signed [17:0] bdelta;
   logic        s_w, s_b;
   weight_type  w_sat, b_sat;
   logic [CW-1:0] cnt_nx;

   always_comb begin
      state_in = state_ff;
      acc_in = add_ff ? acc_ff + (prod_ff >>> 12) : acc_ff;
      prod_in = prod_ff;
      add_in = 1'b0;
      cnt_in = cnt_ff;
      stored_in = stored_ff;
      rot_in = rot_ff;
      upd_in = upd_ff;
      train_in = train_ff;
      label_in = label_ff;
      lerr_in = lerr_ff;
      rdbias_in = rdbias_ff;
      sat_in = sat_ff;
      z_in = z_ff;
      idx_in = idx_ff;
      p_in = p_ff;
      g_in = g_ff;
      uprod_in = uprod_ff;
      bias_in = bias_ff;
      pos_in = pos_ff;
      strobe_in = 1'b0;
      oprob_in = oprob_ff;
      ow_in = ow_ff;
      olerr_in = olerr_ff;
      osat_in = osat_ff;
      ring_shift = 1'b0;
      tail_w = cw[0];
      tail_x = cx[0];
      cnt_nx = (cnt_ff == CW'(MAX_FEATURES + 1)) ? cnt_ff : cnt_ff + CW'(1);

      zsum = 49'(acc_ff) + 49'(bias_ff);
      zoff = {~z_ff[19], z_ff[18:0]};
      iprod = (20+EW)'(zoff) * (20+EW)'(SIGMOID_ENTRIES);
      err = $signed({1'b0, p_ff}) - (label_ff ? 17'sd65536 : 17'sd0);
      wdelta = 22'((uprod_ff + 50'sd134217728) >>> 28);
      bdelta = 18'((g_ff + 34'sd32768) >>> 16);
      w_sat = sat32(33'(cw[0]) - 33'(wdelta), s_w);
      b_sat = sat32(33'(bias_ff) - 33'(bdelta), s_b);

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_opcode == OP_READ) begin
                  rdbias_in = 32'(req_weight_index) >= MAX_FEATURES;
                  if (CW'(req_weight_index) >= stored_ff)
                     pos_in = PW'(CW'(req_weight_index) - stored_ff);
                  else
                     pos_in = PW'(CW'(req_weight_index) + CW'(MAX_FEATURES) - stored_ff);
                  state_in = ST_READ;
               end else if (req_opcode == OP_INFER || req_opcode == OP_TRAIN) begin
                  if (cnt_ff < n_use) begin
                     ring_shift = 1'b1;
                     tail_x = req_feature_value;
                     prod_in = 48'(cw[0]) * 48'(req_feature_value);
                     add_in = 1'b1;
                     stored_in = stored_ff + CW'(1);
                  end
                  cnt_in = cnt_nx;
                  if (req_last_feature) begin
                     lerr_in = cnt_nx != n_use;
                     train_in = req_opcode == OP_TRAIN;
                     label_in = req_label;
                     state_in = ST_ACC;
                  end
               end
            end
         end
         ST_ACC: state_in = ST_Z;
         ST_Z: begin
            if (zsum > 49'sd524287)
               z_in = 20'sh7FFFF;
            else if (zsum < -49'sd524288)
               z_in = 20'sh80000;
            else
               z_in = zsum[19:0];
            state_in = ST_IDX;
         end
         ST_IDX: begin
            idx_in = IW'(iprod >> 20);
            state_in = ST_TAB;
         end
         ST_TAB: begin
            p_in = sig_tab[idx_ff];
            state_in = ST_G;
         end
         ST_G: begin
            g_in = $signed({18'd0, rate_ff}) * 34'(err);
            rot_in = (stored_ff == CW'(MAX_FEATURES)) ? '0 : CW'(MAX_FEATURES) - stored_ff;
            sat_in = 1'b0;
            state_in = ST_ALIGN;
         end
         ST_ALIGN: begin
            if (rot_ff != '0) begin
               ring_shift = 1'b1;
               rot_in = rot_ff - CW'(1);
            end else if (train_ff && !lerr_ff) begin
               upd_in = '0;
               state_in = ST_UPA;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_UPA: begin
            uprod_in = 50'(g_ff) * 50'(cx[0]);
            state_in = ST_UPB;
         end
         ST_UPB: begin
            ring_shift = 1'b1;
            if (CW'(upd_ff) < n_use) begin
               tail_w = w_sat;
               sat_in = sat_ff | s_w;
            end
            upd_in = upd_ff + PW'(1);
            state_in = (32'(upd_ff) == MAX_FEATURES - 1) ? ST_BIAS : ST_UPA;
         end
         ST_BIAS: begin
            bias_in = b_sat;
            sat_in = sat_ff | s_b;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            strobe_in = 1'b1;
            oprob_in = p_ff;
            ow_in = '0;
            olerr_in = lerr_ff;
            osat_in = sat_ff;
            acc_in = '0;
            cnt_in = '0;
            stored_in = '0;
            state_in = ST_IDLE;
         end
         ST_READ: begin
            strobe_in = 1'b1;
            oprob_in = '0;
            ow_in = rdbias_ff ? bias_ff : rd_w_or;
            olerr_in = 1'b0;
            osat_in = 1'b0;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rate_ff <= 16'd655;
         nfeat_ff <= 5'd16;
         bias_ff <= '0;
         acc_ff <= '0;
         add_ff <= 1'b0;
         cnt_ff <= '0;
         stored_ff <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en && csr_index == CSR_RATE)
            rate_ff <= csr_data;
         if (csr_wr_en && csr_index == CSR_NFEAT)
            nfeat_ff <= csr_data[4:0];
         bias_ff <= bias_in;
         acc_ff <= acc_in;
         add_ff <= add_in;
         cnt_ff <= cnt_in;
         stored_ff <= stored_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      rot_ff <= rot_in;
      upd_ff <= upd_in;
      train_ff <= train_in;
      label_ff <= label_in;
      lerr_ff <= lerr_in;
      rdbias_ff <= rdbias_in;
      sat_ff <= sat_in;
      z_ff <= z_in;
      idx_ff <= idx_in;
      p_ff <= p_in;
      g_ff <= g_in;
      uprod_ff <= uprod_in;
      pos_ff <= pos_in;
      oprob_ff <= oprob_in;
      ow_ff <= ow_in;
      olerr_ff <= olerr_in;
      osat_ff <= osat_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_probability = oprob_ff;
   assign rsp_predicted_class = oprob_ff[15];
   assign rsp_weight_value = ow_ff;
   assign rsp_length_error = olerr_ff;
   assign rsp_saturated = osat_ff;

   a_strobe_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff == ST_OUT || state_ff == ST_READ))
      else $error("result without finishing transaction");
   a_stored_le_count: assert property (@(posedge clock) disable iff (reset)
      stored_ff <= cnt_ff && stored_ff <= CW'(MAX_FEATURES))
      else $error("stored feature count out of range");
   a_update_only_train: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPA || state_ff == ST_UPB) |-> (train_ff && !lerr_ff))
      else $error("weight update without valid train sample");
   a_idle_after_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> state_ff == ST_IDLE)
      else $error("busy at result");

endmodule

FILE: rtl/core/lrs_cell.sv
// ----------------------------------------------------------------------------
// lrs_cell
// One ring cell: holds a weight and a feature, loads from its neighbor.
// ----------------------------------------------------------------------------
module lrs_cell #(
   parameter int PW = 4,
   parameter int IDX = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 shift_en,
   input  lrs_pkg::weight_type  w_in,
   input  lrs_pkg::feature_type x_in,
   input  logic [PW-1:0]        rd_pos,
   output lrs_pkg::weight_type  w_out,
   output lrs_pkg::feature_type x_out,
   output lrs_pkg::weight_type  rd_w
);
   import lrs_pkg::*;

   weight_type  w_ff;
   feature_type x_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         w_ff <= '0;
      end else if (shift_en) begin
         w_ff <= w_in;
      end
   end

   always_ff @(posedge clock) begin
      if (shift_en) begin
         x_ff <= x_in;
      end
   end

   assign w_out = w_ff;
   assign x_out = x_ff;
   assign rd_w  = (rd_pos == PW'(IDX)) ? w_ff : '0;

endmodule

FILE: test/logistic_regression_sgd_core_tb.sv
// ----------------------------------------------------------------------------
// logistic_regression_sgd_core_tb
// Self-checking bench for the online logistic regression SGD core. Directed
// and random samples in infer and train mode, weight reads, opcode noise and
// length mismatches are checked against a bit-exact predictor held in the
// bench. The predictor tracks the weights, the bias and the learning settings.
// ----------------------------------------------------------------------------
module logistic_regression_sgd_core_tb;
   import lrs_pkg::*;

   localparam int NFEAT = MaxFeatures;
   localparam int NSIG  = SigmoidEntries;
   localparam int ZLIM  = 524288;
   localparam longint CYCLE_LIMIT = 600000;

   localparam logic [1:0] OP_INFER = 2'd0;
   localparam logic [1:0] OP_TRAIN = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;
   localparam logic [1:0] OP_NONE  = 2'd3;
   localparam logic CSR_RATE  = 1'b0;
   localparam logic CSR_NFEAT = 1'b1;

   typedef struct {
      logic [15:0] prob;
      logic        cls;
      logic [31:0] wval;
      logic        lerr;
      logic        sat;
   } result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [1:0] req_opcode = '0;
   feature_type req_feature_value = '0;
   logic req_last_feature = 1'b0;
   logic req_label = 1'b0;
   logic [4:0] req_weight_index = '0;
   logic rsp_strobe;
   logic [15:0] rsp_probability;
   logic rsp_predicted_class;
   weight_type rsp_weight_value;
   logic rsp_length_error;
   logic rsp_saturated;
   logic csr_wr_en = 1'b0;
   logic csr_index = 1'b0;
   logic [15:0] csr_data = '0;

   logistic_regression_sgd_core dut (.*);

   always #1 clock = ~clock;

   // predictor state
   logic [15:0] rate_q16;
   logic [4:0]  feat_cfg;
   logic signed [15:0] feat_mem [NFEAT];
   longint weight_mem [NFEAT];
   longint bias_q;
   int unsigned elem_cnt;
   longint dot_acc;
   logic [15:0] sig_lut [NSIG];

   result_type pending_q [$];
   int errors = 0;
   int n_sent = 0, n_results = 0, n_train = 0, n_lenerr = 0, n_reads = 0;
   longint cycles = 0;
   bit no_gaps = 0;

   function automatic logic [15:0] sigmoid_q16(longint z);
      longint unsigned exp2_root [16] = '{92682, 77936, 71468, 68438, 66971,
         66250, 65892, 65714, 65625, 65580, 65558, 65547, 65542, 65539,
         65537, 65537};
      longint unsigned t, u, m, e, d, p;
      int unsigned k;
      t = (z < 0) ? longint'(-z) : longint'(z);
      u = (t * 64'd94548) >> 16;
      k = 32'(u >> 16);
      m = 65536;
      for (int j = 0; j < 16; j++)
         if (u[15 - j]) m = (m * exp2_root[j] + 32768) >> 16;
      if (k > 20) k = 20;
      e = m << k;
      d = e + 65536;
      if (z >= 0) p = (e * 65536 + d / 2) / d;
      else p = (64'h1_0000_0000 + d / 2) / d;
      return (p > 65535) ? 16'hFFFF : p[15:0];
   endfunction

   function automatic longint clip_sub(longint w, longint delta, ref bit sat);
      longint r;
      r = w - delta;
      if (r > 64'sd2147483647) begin
         sat = 1;
         return 64'sd2147483647;
      end
      if (r < -64'sd2147483648) begin
         sat = 1;
         return -64'sd2147483648;
      end
      return r;
   endfunction

   task automatic predictor_reset();
      rate_q16 = 16'd655;
      feat_cfg = 5'd16;
      for (int i = 0; i < NFEAT; i++) begin
         feat_mem[i] = '0;
         weight_mem[i] = 0;
      end
      bias_q = 0;
      elem_cnt = 0;
      dot_acc = 0;
      for (int i = 0; i < NSIG; i++)
         sig_lut[i] = sigmoid_q16(-ZLIM + ((2 * longint'(i) + 1) * ZLIM) / NSIG);
   endtask

   task automatic enqueue_result(result_type r);
      pending_q.insert(pending_q.size(), r);
   endtask

   // updates model state for one accepted transaction, queues any result
   task automatic predict_item(logic [1:0] op, logic signed [15:0] x, logic last,
                               logic lab, logic [4:0] idx);
      int unsigned n;
      longint z, g, d;
      logic [15:0] p;
      bit sat;
      bit lerr;
      result_type r;
      n = (feat_cfg < 1) ? 1 : (feat_cfg > NFEAT) ? NFEAT : feat_cfg;
      sat = 0;
      if (op == OP_NONE) return;
      if (op == OP_READ) begin
         r = '{16'd0, 1'b0, 32'd0, 1'b0, 1'b0};
         r.wval = (idx < NFEAT) ? 32'(weight_mem[idx]) : 32'(bias_q);
         enqueue_result(r);
         n_reads++;
         return;
      end
      if (elem_cnt < n) begin
         feat_mem[elem_cnt] = x;
         dot_acc += (weight_mem[elem_cnt] * longint'(x)) >>> 12;
      end
      if (elem_cnt <= NFEAT) elem_cnt++;
      if (!last) return;
      lerr = (elem_cnt != n);
      z = dot_acc + bias_q;
      if (z > ZLIM - 1) z = ZLIM - 1;
      if (z < -ZLIM) z = -ZLIM;
      p = sig_lut[((z + ZLIM) * NSIG) >>> 20];
      if (op == OP_TRAIN && !lerr) begin
         g = longint'(rate_q16) * (longint'(p) - (lab ? 65536 : 0));
         for (int j = 0; j < n; j++) begin
            d = (g * longint'(feat_mem[j]) + (64'sd1 <<< 27)) >>> 28;
            weight_mem[j] = clip_sub(weight_mem[j], d, sat);
         end
         bias_q = clip_sub(bias_q, (g + 32768) >>> 16, sat);
         n_train++;
      end
      if (lerr) n_lenerr++;
      elem_cnt = 0;
      dot_acc = 0;
      r.prob = p;
      r.cls = (p >= 16'd32768);
      r.wval = '0;
      r.lerr = lerr;
      r.sat = sat;
      enqueue_result(r);
   endtask

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // result checker
   always @(posedge clock) begin
      result_type e;
      if (!reset && rsp_strobe) begin
         n_results++;
         if (pending_q.size() == 0) begin
            $error("unexpected result transaction");
            errors++;
         end else begin
            e = pending_q.pop_front();
            if (rsp_probability !== e.prob) begin
               $error("probability exp %0d got %0d", e.prob, rsp_probability);
               errors++;
            end
            if (rsp_predicted_class !== e.cls) begin
               $error("predicted_class exp %0d got %0d", e.cls, rsp_predicted_class);
               errors++;
            end
            if (rsp_weight_value !== e.wval) begin
               $error("weight_value exp %0d got %0d", $signed(e.wval), rsp_weight_value);
               errors++;
            end
            if (rsp_length_error !== e.lerr) begin
               $error("length_error exp %0d got %0d", e.lerr, rsp_length_error);
               errors++;
            end
            if (rsp_saturated !== e.sat) begin
               $error("saturated exp %0d got %0d", e.sat, rsp_saturated);
               errors++;
            end
         end
      end
   end

   task automatic send_item(logic [1:0] op, logic [15:0] x, logic last, logic lab,
                            logic [4:0] idx);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 16);
      repeat (gap) @(negedge clock);
      start = 1'b1;
      req_opcode = op;
      req_feature_value = x;
      req_last_feature = last;
      req_label = lab;
      req_weight_index = idx;
      do @(posedge clock); while (busy);
      predict_item(op, x, last, lab, idx);
      n_sent++;
      @(negedge clock);
      start = 1'b0;
   endtask

   task automatic wait_drain();
      while (pending_q.size() != 0) @(negedge clock);
      repeat (80) @(negedge clock);
   endtask

   task automatic write_csr(logic idx, logic [15:0] val);
      wait_drain();
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_data = val;
      @(negedge clock);
      csr_wr_en = 1'b0;
      if (idx == CSR_RATE) rate_q16 = val;
      else feat_cfg = val[4:0];
   endtask

   function automatic logic [15:0] rand_feature();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'($signed($urandom_range(0, 8192)) - 4096);
         default: return 16'($urandom);
      endcase
   endfunction

   // len elements, last carries the deciding opcode; reads may be interleaved
   task automatic send_sample(int len, logic [1:0] last_op, logic lab, bit with_reads);
      for (int i = 0; i < len; i++) begin
         if (with_reads && $urandom_range(0, 7) == 0)
            send_item(OP_READ, 16'($urandom), 1'b0, 1'($urandom), 5'($urandom));
         if (i == len - 1) send_item(last_op, rand_feature(), 1'b1, lab, 5'($urandom));
         else send_item(2'($urandom_range(0, 1)), rand_feature(), 1'b0,
                        1'($urandom), 5'($urandom));
      end
   endtask

   task automatic test_read_all();
      for (int i = 0; i < 32; i++)
         send_item(OP_READ, 16'h0, 1'b0, 1'b0, 5'(i));
   endtask

   task automatic test_directed();
      for (int i = 0; i < 16; i++)
         send_item(OP_TRAIN, (i % 2) ? 16'h7FFF : 16'h8000, i == 15, 1'b1, 5'd0);
      send_item(OP_NONE, 16'h1234, 1'b1, 1'b0, 5'd3);
      send_sample(16, OP_INFER, 1'b0, 1);
      send_sample(5, OP_TRAIN, 1'b0, 0);
      send_sample(20, OP_TRAIN, 1'b1, 0);
      send_sample(16, OP_TRAIN, 1'b0, 1);
   endtask

   task automatic test_config_extremes();
      write_csr(CSR_RATE, 16'hFFFF);
      write_csr(CSR_NFEAT, 16'd1);
      for (int i = 0; i < 6; i++) send_sample(1, OP_TRAIN, 1'(i), 0);
      send_sample(2, OP_TRAIN, 1'b1, 0);
      write_csr(CSR_RATE, 16'h0000);
      write_csr(CSR_NFEAT, 16'd16);
      send_sample(16, OP_TRAIN, 1'b1, 0);
      test_read_all();
   endtask

   task automatic test_random(int items);
      int goal;
      goal = n_sent + items;
      while (n_sent < goal) begin
         if ($urandom_range(0, 9) == 0) no_gaps = ~no_gaps;
         if ($urandom_range(0, 39) == 0) begin
            write_csr(CSR_RATE, ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom));
            write_csr(CSR_NFEAT, 16'($urandom_range(1, 16)));
         end
         case ($urandom_range(0, 9))
            0: send_item(2'($urandom_range(2, 3)), 16'($urandom), 1'($urandom),
                         1'($urandom), 5'($urandom));
            1: send_sample($urandom_range(1, 19), 2'($urandom_range(0, 1)),
                           1'($urandom), 1);
            default: send_sample((feat_cfg < 1) ? 1 : feat_cfg,
                                 2'($urandom_range(0, 1)), 1'($urandom), 1);
         endcase
      end
      no_gaps = 0;
   endtask

   task automatic test_drain_pause();
      send_sample(16, OP_TRAIN, 1'b0, 0);
      while (pending_q.size() != 0) @(negedge clock);
      send_item(OP_READ, 16'h0, 1'b0, 1'b0, 5'd16);
   endtask

   initial begin
      predictor_reset();
      repeat (2) @(negedge clock);
      reset = 1'b0;
      test_read_all();
      test_directed();
      test_config_extremes();
      test_drain_pause();
      test_random(835);
      write_csr(CSR_RATE, 16'd655);
      test_read_all();
      wait_drain();
      $display("Ran %0d transactions, %0d results: %0d training updates, %0d length errors,",
               n_sent, n_results, n_train, n_lenerr);
      $display("%0d weight reads, with learning-rate and feature-count changes between phases.",
               n_reads);
      if (errors == 0 && pending_q.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
